### design/ttce_pkg.sv
package ttce_pkg;

   localparam int COL_W    = 7;
   localparam int ROW_W    = 5;
   localparam int LINEAR_W = 11;
   localparam int CELL_W   = 16;
   localparam int CHAR_W   = 8;
   localparam int COLOR_W  = 8;

   localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0]  CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'd32;
   localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

   typedef enum logic [1:0] {
      REQ_PUT   = 2'd0,
      REQ_MOVE  = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_READ  = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_PRINT,
      ST_BLANK_CELL,
      ST_SCROLL,
      ST_SCROLL_BLANK,
      ST_FILL,
      ST_RD_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                valid;
      logic [COL_W-1:0]    cursor_col;
      logic [ROW_W-1:0]    cursor_row;
      logic [LINEAR_W-1:0] cursor_linear;
      logic [CELL_W-1:0]   cell_data;
   } result_type;

endpackage

### design/ttce_cell_ram.sv
module ttce_cell_ram #(
   parameter int DEPTH = 2000,
   parameter int AW    = 11
) (
   input  logic                      clock,
   input  logic                      wr_en,
   input  logic [AW-1:0]             wr_addr,
   input  logic [ttce_pkg::CELL_W-1:0] wr_data,
   input  logic [AW-1:0]             rd_addr,
   output logic [ttce_pkg::CELL_W-1:0] rd_data
);
   import ttce_pkg::*;

   logic [CELL_W-1:0] mem [DEPTH];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### design/ttce_ctrl.sv
module ttce_ctrl #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4,
   parameter int AW        = 11
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_type,
   input  logic [ttce_pkg::CHAR_W-1:0]   req_char_code,
   input  logic [ttce_pkg::COL_W-1:0]    req_target_col,
   input  logic [ttce_pkg::ROW_W-1:0]    req_target_row,
   input  logic                          csr_wr_en,
   input  logic [ttce_pkg::COLOR_W-1:0]  csr_wr_data,
   input  logic                          out_free,
   output ttce_pkg::result_type          result,
   output logic                          wr_en,
   output logic [AW-1:0]                 wr_addr,
   output logic [ttce_pkg::CELL_W-1:0]   wr_data,
   output logic [AW-1:0]                 rd_addr,
   input  logic [ttce_pkg::CELL_W-1:0]   rd_data
);
   import ttce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int TW    = $clog2(TAB_WIDTH + 1);
   localparam logic [AW-1:0] CNT_LAST    = AW'(CELLS - 1);
   localparam logic [AW-1:0] COPY_LAST   = AW'(CELLS - COLUMNS - 1);
   localparam logic [AW-1:0] BOTTOM_ROW  = AW'(CELLS - COLUMNS);
   localparam logic [AW-1:0] ROW_STRIDE  = AW'(COLUMNS);

   state_type          state_ff, state_in;
   req_kind_type       kind_ff, kind_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic [COL_W-1:0]   tcol_ff, tcol_in;
   logic [ROW_W-1:0]   trow_ff, trow_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic [TW-1:0]      tab_ff, tab_in;
   logic               pend_valid_ff, pend_valid_in;
   logic [AW-1:0]      pend_addr_ff, pend_addr_in;
   logic [CELL_W-1:0]  data_ff, data_in;

   logic              in_range, col_last, row_last, cnt_last;
   logic [AW-1:0]     cur_addr, target_addr;
   logic [CELL_W-1:0] blank;

   // cursor/target address unit
   assign cur_addr    = AW'(int'(row_ff) * COLUMNS + int'(col_ff));
   assign target_addr = AW'(int'(trow_ff) * COLUMNS + int'(tcol_ff));
   assign in_range    = ({1'b0, tcol_ff} < 8'(COLUMNS)) && ({1'b0, trow_ff} < 6'(ROWS));
   assign col_last    = (col_ff == COL_W'(COLUMNS - 1));
   assign row_last    = (row_ff == ROW_W'(ROWS - 1));
   assign cnt_last    = (cnt_ff == CNT_LAST);
   assign blank       = {color_ff, CH_SPACE};
   assign req_stall   = (state_ff != ST_IDLE);

   always_comb begin : next_state
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (cnt_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            case (kind_ff)
               REQ_PUT: begin
                  if (char_ff == CH_NEWLINE) begin
                     state_in = row_last ? ST_SCROLL : ST_DONE;
                  end else if (char_ff == CH_RETURN) begin
                     state_in = ST_DONE;
                  end else if (char_ff == CH_BACKSPACE) begin
                     state_in = (col_ff != '0 || row_ff != '0) ? ST_BLANK_CELL : ST_DONE;
                  end else begin
                     state_in = ST_PRINT;
                  end
               end
               REQ_MOVE:  state_in = ST_DONE;
               REQ_CLEAR: state_in = ST_FILL;
               REQ_READ:  state_in = ST_RD_WAIT;
               default:   state_in = ST_DONE;
            endcase
         end
         ST_PRINT: begin
            if (col_last && row_last) state_in = ST_SCROLL;
            else if (tab_ff != TW'(1)) state_in = ST_PRINT;
            else state_in = ST_DONE;
         end
         ST_SCROLL: begin
            if (cnt_ff == COPY_LAST) state_in = ST_SCROLL_BLANK;
         end
         ST_SCROLL_BLANK: begin
            if (!pend_valid_ff && cnt_last) begin
               state_in = (tab_ff != '0) ? ST_PRINT : ST_DONE;
            end
         end
         ST_FILL: begin
            if (cnt_last) state_in = ST_DONE;
         end
         ST_RD_WAIT:    state_in = ST_DONE;
         ST_BLANK_CELL: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin : datapath
      kind_in       = kind_ff;
      char_in       = char_ff;
      tcol_in       = tcol_ff;
      trow_in       = trow_ff;
      col_in        = col_ff;
      row_in        = row_ff;
      color_in      = csr_wr_en ? csr_wr_data : color_ff;
      cnt_in        = cnt_ff;
      tab_in        = tab_ff;
      pend_valid_in = 1'b0;
      pend_addr_in  = pend_addr_ff;
      data_in       = data_ff;
      rd_addr       = target_addr;
      wr_en         = 1'b0;
      wr_addr       = cur_addr;
      wr_data       = blank;
      result.valid  = 1'b0;

      // copy write lands in the cycle after its scroll read
      if (pend_valid_ff) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = rd_data;
      end

      case (state_ff)
         ST_INIT, ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = (state_ff == ST_INIT) ? {RESET_COLOR, CH_SPACE} : blank;
            cnt_in  = cnt_last ? '0 : cnt_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_kind_type'(req_type);
               char_in = req_char_code;
               tcol_in = req_target_col;
               trow_in = req_target_row;
            end
         end
         ST_DECODE: begin
            data_in = '0;
            tab_in  = '0;
            cnt_in  = '0;
            case (kind_ff)
               REQ_PUT: begin
                  if (char_ff == CH_NEWLINE) begin
                     col_in = '0;
                     if (!row_last) row_in = row_ff + 1'b1;
                  end else if (char_ff == CH_RETURN) begin
                     col_in = '0;
                  end else if (char_ff == CH_BACKSPACE) begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end else if (row_ff != '0) begin
                        row_in = row_ff - 1'b1;
                        col_in = COL_W'(COLUMNS - 1);
                     end
                  end else if (char_ff == CH_TAB) begin
                     tab_in  = TW'(TAB_WIDTH);
                     char_in = CH_SPACE;
                  end else begin
                     tab_in = TW'(1);
                  end
               end
               REQ_MOVE: begin
                  if (in_range) begin
                     col_in = tcol_ff;
                     row_in = trow_ff;
                  end
               end
               REQ_CLEAR: begin
                  col_in = '0;
                  row_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_PRINT: begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = {color_ff, char_ff};
            tab_in  = tab_ff - 1'b1;
            cnt_in  = '0;
            if (col_last) begin
               col_in = '0;
               if (!row_last) row_in = row_ff + 1'b1;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_SCROLL: begin
            rd_addr       = cnt_ff + ROW_STRIDE;
            pend_valid_in = 1'b1;
            pend_addr_in  = cnt_ff;
            cnt_in        = (cnt_ff == COPY_LAST) ? BOTTOM_ROW : cnt_ff + 1'b1;
         end
         ST_SCROLL_BLANK: begin
            if (!pend_valid_ff) begin
               wr_en   = 1'b1;
               wr_addr = cnt_ff;
               wr_data = blank;
               cnt_in  = cnt_last ? '0 : cnt_ff + 1'b1;
            end
         end
         ST_RD_WAIT: begin
            data_in = in_range ? rd_data : '0;
         end
         ST_BLANK_CELL: begin
            wr_en   = 1'b1;
            wr_addr = cur_addr;
            wr_data = blank;
         end
         ST_DONE: begin
            result.valid = out_free;
         end
         default: begin
         end
      endcase

      result.cursor_col    = col_ff;
      result.cursor_row    = row_ff;
      result.cursor_linear = LINEAR_W'(int'(row_ff) * COLUMNS + int'(col_ff));
      result.cell_data     = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT;
         col_ff        <= '0;
         row_ff        <= '0;
         color_ff      <= RESET_COLOR;
         cnt_ff        <= '0;
         tab_ff        <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         color_ff      <= color_in;
         cnt_ff        <= cnt_in;
         tab_ff        <= tab_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      char_ff      <= char_in;
      tcol_ff      <= tcol_in;
      trow_ff      <= trow_in;
      pend_addr_ff <= pend_addr_in;
      data_ff      <= data_in;
   end

endmodule

### design/text_terminal_cell_engine.sv
// Each accepted word is decoded, then carried out: a tab prints TAB_WIDTH spaces; a scroll
// copies rows up at one cell per cycle, then blanks the bottom row; a clear blanks every
// cell. One request in flight: the next word is taken once the sequencer is back in idle.
// Reset (synchronous, active high) homes the cursor, sets color 0x07 and runs a clearing
// pass that writes spaces to every cell; no word is taken until it ends.
module text_terminal_cell_engine #(
   parameter int COLUMNS   = 80,
   parameter int ROWS      = 25,
   parameter int TAB_WIDTH = 4
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_type,
   input  logic [ttce_pkg::CHAR_W-1:0]     req_char_code,
   input  logic [ttce_pkg::COL_W-1:0]      req_target_col,
   input  logic [ttce_pkg::ROW_W-1:0]      req_target_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ttce_pkg::COL_W-1:0]      rsp_cursor_col,
   output logic [ttce_pkg::ROW_W-1:0]      rsp_cursor_row,
   output logic [ttce_pkg::LINEAR_W-1:0]   rsp_cursor_linear,
   output logic [ttce_pkg::CELL_W-1:0]     rsp_cell_data,
   input  logic                            csr_wr_en,
   input  logic [ttce_pkg::COLOR_W-1:0]    csr_wr_data
);
   import ttce_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);

   // cell RAM port
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [CELL_W-1:0] wr_data;
   logic [AW-1:0]     rd_addr;
   logic [CELL_W-1:0] rd_data;

   // handoff from sequencer into the output register
   result_type result;
   logic       out_free;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COL_W-1:0]    col_ff;
   logic [ROW_W-1:0]    row_ff;
   logic [LINEAR_W-1:0] linear_ff;
   logic [CELL_W-1:0]   data_ff;

   // Sequencer: decode, cursor math, scroll/clear walks over the shared RAM port.
   ttce_ctrl #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH),
      .AW        (AW)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_char_code  (req_char_code),
      .req_target_col (req_target_col),
      .req_target_row (req_target_row),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .out_free       (out_free),
      .result         (result),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data)
   );

   // Frame store: one write, one registered read per cycle.
   ttce_cell_ram #(
      .DEPTH (CELLS),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Output register: holds a finished word while the sink stalls; the
   // sequencer can take the next request meanwhile.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = result.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result.valid) begin
         col_ff    <= result.cursor_col;
         row_ff    <= result.cursor_row;
         linear_ff <= result.cursor_linear;
         data_ff   <= result.cell_data;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_cursor_col    = col_ff;
   assign rsp_cursor_row    = row_ff;
   assign rsp_cursor_linear = linear_ff;
   assign rsp_cell_data     = data_ff;

   // cursor reported is always on screen
   a_cursor_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_cursor_col} < 8'(COLUMNS)) &&
                    ({1'b0, rsp_cursor_row} < 6'(ROWS)))
      else $error("cursor off screen");

   // clearing pass keeps the input closed right after reset
   a_stall_after_reset: assert property (@(posedge clock)
      $past(reset) |-> req_stall)
      else $error("input open during clearing pass");

   // a stalled word stays put until the sink takes it
   a_result_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_cursor_col) &&
         $stable(rsp_cursor_row) && $stable(rsp_cursor_linear) && $stable(rsp_cell_data))
      else $error("stalled result changed");

   // the RAM write port is never claimed by a scroll copy outside a scroll
   a_copy_in_scroll: assert property (@(posedge clock) disable iff (reset)
      u_ctrl.pend_valid_ff |-> (u_ctrl.state_ff == ST_SCROLL) ||
                               (u_ctrl.state_ff == ST_SCROLL_BLANK))
      else $error("copy write outside scroll");

endmodule

### bench/text_terminal_cell_engine_tb.sv
module text_terminal_cell_engine_tb;
   import ttce_pkg::*;

   localparam int COLUMNS   = 80;
   localparam int ROWS      = 25;
   localparam int TAB_WIDTH = 4;
   localparam int CELLS     = COLUMNS * ROWS;

   // Longest request is a tab that wraps into a scroll: a full buffer walk plus the tab's prints.
   // After the last result we sit this long so a stray extra word would still be caught.
   localparam int LINGER = CELLS + TAB_WIDTH + 200;

   // Random stimulus, split so the color register can be rewritten between phases.
   localparam int PHASES          = 8;
   localparam int WORDS_PER_PHASE = 103;

   // Worst legal run is every word scrolling (each a full buffer walk) plus stalls and gaps;
   // this is a few times that.
   localparam int LIMIT_CYCLES = 8_000_000;

   // One request word as the sender sees it.
   typedef struct {
      req_kind_type      kind;
      logic [CHAR_W-1:0] char_code;
      logic [COL_W-1:0]  target_col;
      logic [ROW_W-1:0]  target_row;
   } console_req_t;

   // Cursor report as the block should return it.
   typedef struct {
      logic [COL_W-1:0]    col;
      logic [ROW_W-1:0]    row;
      logic [LINEAR_W-1:0] linear;
      logic [CELL_W-1:0]   data;
   } cursor_report_t;

   // Shadow console: own frame store, cursor and color, plus the queue of cursor reports
   // still owed by the block.
   class cell_books;
      logic [CELL_W-1:0]  frame [CELLS];
      logic [COL_W-1:0]   col;
      logic [ROW_W-1:0]   row;
      logic [COLOR_W-1:0] color;
      cursor_report_t     outstanding [$];
      int                 errors;
      int                 checked;
      int                 scrolls;
      int                 tabs;
      int                 rubs;
      int                 kinds [4];

      function new();
         color   = RESET_COLOR;
         col     = '0;
         row     = '0;
         errors  = 0;
         checked = 0;
         scrolls = 0;
         tabs    = 0;
         rubs    = 0;
         foreach (kinds[k]) kinds[k] = 0;
         wipe();
      endfunction

      function logic [CELL_W-1:0] blank();
         return {color, CH_SPACE};
      endfunction

      function void wipe();
         foreach (frame[i]) frame[i] = blank();
      endfunction

      function void poke(int c, int r, logic [CELL_W-1:0] v);
         if (c < COLUMNS && r < ROWS) frame[r * COLUMNS + c] = v;
      endfunction

      function void line_feed();
         col = '0;
         if (int'(row) >= ROWS - 1) begin
            for (int i = 0; i < CELLS - COLUMNS; i++) frame[i] = frame[i + COLUMNS];
            for (int i = CELLS - COLUMNS; i < CELLS; i++) frame[i] = blank();
            scrolls++;
         end else begin
            row++;
         end
      endfunction

      function void print_char(logic [CHAR_W-1:0] ch);
         poke(int'(col), int'(row), {color, ch});
         if (int'(col) >= COLUMNS - 1) line_feed();
         else col++;
      endfunction

      function void rub_out();
         if (col != 0) begin
            col--;
            poke(int'(col), int'(row), blank());
         end else if (row != 0) begin
            row--;
            col = COL_W'(COLUMNS - 1);
            poke(int'(col), int'(row), blank());
         end
      endfunction

      function void note_request(console_req_t w);
         cursor_report_t    due;
         logic [CELL_W-1:0] data;
         bit                in_range;
         data     = '0;
         in_range = int'(w.target_col) < COLUMNS && int'(w.target_row) < ROWS;
         kinds[w.kind]++;
         case (w.kind)
            REQ_PUT: begin
               if (w.char_code == CH_NEWLINE) begin
                  line_feed();
               end else if (w.char_code == CH_RETURN) begin
                  col = '0;
               end else if (w.char_code == CH_BACKSPACE) begin
                  rubs++;
                  rub_out();
               end else if (w.char_code == CH_TAB) begin
                  tabs++;
                  repeat (TAB_WIDTH) print_char(CH_SPACE);
               end else begin
                  print_char(w.char_code);
               end
            end
            REQ_MOVE: begin
               if (in_range) begin
                  col = w.target_col;
                  row = w.target_row;
               end
            end
            REQ_CLEAR: begin
               wipe();
               col = '0;
               row = '0;
            end
            default: begin
               if (in_range) data = frame[int'(w.target_row) * COLUMNS + int'(w.target_col)];
            end
         endcase
         due.col    = col;
         due.row    = row;
         due.linear = LINEAR_W'(int'(row) * COLUMNS + int'(col));
         due.data   = data;
         outstanding.push_back(due);
      endfunction

      function void check_result(logic [COL_W-1:0] c, logic [ROW_W-1:0] r,
                                 logic [LINEAR_W-1:0] lin, logic [CELL_W-1:0] d);
         cursor_report_t due;
         if (outstanding.size() == 0) begin
            $error("cursor report with no request outstanding: col %0d row %0d", c, r);
            errors++;
            return;
         end
         due = outstanding.pop_front();
         checked++;
         if (c !== due.col) begin
            $error("cursor_col: expected %0d, got %0d", due.col, c);
            errors++;
         end
         if (r !== due.row) begin
            $error("cursor_row: expected %0d, got %0d", due.row, r);
            errors++;
         end
         if (lin !== due.linear) begin
            $error("cursor_linear: expected %0d, got %0d", due.linear, lin);
            errors++;
         end
         if (d !== due.data) begin
            $error("cell_data: expected 0x%04h, got 0x%04h", due.data, d);
            errors++;
         end
      endfunction

      function int pending();
         return outstanding.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_type;
   logic [CHAR_W-1:0]   req_char_code;
   logic [COL_W-1:0]    req_target_col;
   logic [ROW_W-1:0]    req_target_row;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [COL_W-1:0]    rsp_cursor_col;
   logic [ROW_W-1:0]    rsp_cursor_row;
   logic [LINEAR_W-1:0] rsp_cursor_linear;
   logic [CELL_W-1:0]   rsp_cell_data;
   logic                csr_wr_en;
   logic [COLOR_W-1:0]  csr_wr_data;

   cell_books books = new();

   // Words left in the current sender burst; a gap follows when it runs out.
   int burst_left = 0;
   int color_writes = 0;

   text_terminal_cell_engine #(
      .COLUMNS   (COLUMNS),
      .ROWS      (ROWS),
      .TAB_WIDTH (TAB_WIDTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_type          (req_type),
      .req_char_code     (req_char_code),
      .req_target_col    (req_target_col),
      .req_target_row    (req_target_row),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_cursor_col    (rsp_cursor_col),
      .rsp_cursor_row    (rsp_cursor_row),
      .rsp_cursor_linear (rsp_cursor_linear),
      .rsp_cell_data     (rsp_cell_data),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always #5 clock = ~clock;

   // Present one word and hold it until the block takes it. Called at a rising edge;
   // returns at the edge where the word was accepted. Valid drops only when a burst
   // ends (or on the last word of a phase), and any gap waits on the clock before the
   // next word so valid never gets two assignments in one step.
   task automatic send_word(input console_req_t w, input bit last = 1'b0);
      req_valid      <= 1'b1;
      req_type       <= w.kind;
      req_char_code  <= w.char_code;
      req_target_col <= w.target_col;
      req_target_row <= w.target_row;
      @(posedge clock);
      while (req_stall !== 1'b0) @(posedge clock);
      books.note_request(w);
      if (last || burst_left == 0) begin
         req_valid <= 1'b0;
         if (!last) begin
            if ($urandom_range(0, 7) == 0) repeat ($urandom_range(5, 40)) @(posedge clock);
            else repeat ($urandom_range(1, 4)) @(posedge clock);
         end
         // mostly short bursts, now and then a long back-to-back run
         if ($urandom_range(0, 3) == 0) burst_left = $urandom_range(20, 60);
         else burst_left = $urandom_range(0, 6);
      end else begin
         burst_left--;
      end
   endtask

   task automatic offer(input req_kind_type kind, input logic [CHAR_W-1:0] ch,
                        input int c, input int r, input bit last = 1'b0);
      console_req_t w;
      w.kind       = kind;
      w.char_code  = ch;
      w.target_col = COL_W'(c);
      w.target_row = ROW_W'(r);
      send_word(w, last);
   endtask

   // Wait until every report is in, then let the block settle before touching the
   // color register or ending the run.
   task automatic drain();
      while (books.pending() != 0) @(posedge clock);
      repeat (LINGER) @(posedge clock);
   endtask

   // Only called with the block idle; the shadow color changes at the same edge.
   task automatic set_color(input logic [COLOR_W-1:0] c);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      books.color = c;
      color_writes++;
   endtask

   // Random word. Mostly text with control codes mixed in; moves keep the cursor
   // wandering so scrolls stay occasional, and reads often look right behind the
   // cursor to see freshly written cells.
   function automatic console_req_t pick_word();
      console_req_t w;
      int unsigned  roll;
      int unsigned  back;
      w.kind       = REQ_PUT;
      w.char_code  = CHAR_W'($urandom_range(0, 255));
      w.target_col = COL_W'($urandom_range(0, 127));
      w.target_row = ROW_W'($urandom_range(0, 31));
      roll = $urandom_range(0, 999);
      if (roll >= 990) begin
         w.kind = REQ_CLEAR;
      end else if (roll >= 800) begin
         w.kind = REQ_READ;
         case ($urandom_range(0, 4))
            0, 1: begin
               back = $urandom_range(0, 6);
               w.target_col = (books.col >= back) ? COL_W'(books.col - back) : books.col;
               w.target_row = books.row;
            end
            2, 3: begin
               w.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
               w.target_row = ROW_W'($urandom_range(0, ROWS - 1));
            end
            default: ; // anywhere, out of range included
         endcase
      end else if (roll >= 650) begin
         w.kind = REQ_MOVE;
         case ($urandom_range(0, 4))
            0: begin
               // near the bottom right so wraps and scrolls come up
               w.target_col = COL_W'(COLUMNS - 1 - $urandom_range(0, 3));
               w.target_row = ROW_W'(ROWS - 1);
            end
            1: ; // anywhere, out of range included
            default: begin
               w.target_col = COL_W'($urandom_range(0, COLUMNS - 1));
               w.target_row = ROW_W'($urandom_range(0, ROWS - 1));
            end
         endcase
      end else if (roll >= 600) begin
         w.char_code = CH_TAB;
      end else if (roll >= 520) begin
         w.char_code = CH_BACKSPACE;
      end else if (roll >= 500) begin
         w.char_code = CH_RETURN;
      end else if (roll >= 450) begin
         w.char_code = CH_NEWLINE;
      end
      return w;
   endfunction

   // Receiver: checks every accepted report and drives its own stall pattern. The
   // pattern rotates through no stall, light, heavy and alternating stretches. At a few
   // points it holds off for a long stretch while the sender keeps offering, so the
   // block's output slot and then its sequencer fill and it stalls its input.
   initial begin : result_side
      int unsigned tick;
      int unsigned hold_left;
      int unsigned hold_mark;
      tick      = 0;
      hold_left = 0;
      hold_mark = 150;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid === 1'b1 && !rsp_stall)
            books.check_result(rsp_cursor_col, rsp_cursor_row, rsp_cursor_linear,
                               rsp_cell_data);
         tick++;
         if (hold_left == 0 && books.checked >= hold_mark) begin
            hold_left = 600;
            hold_mark += 350;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case ((tick / 97) % 4)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= tick[0];
            endcase
         end
      end
   end

   initial begin : stimulus
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_type       = REQ_PUT;
      req_char_code  = '0;
      req_target_col = '0;
      req_target_row = '0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed words at the reset color. The block runs its clearing pass first and
      // holds off input until it is done.
      offer(REQ_READ, '0, 0, 0);              // cleared cell: space in color 07
      offer(REQ_READ, '0, COLUMNS, 0);        // column out of range reads 0
      offer(REQ_READ, '0, 0, ROWS);           // row out of range reads 0
      offer(REQ_READ, '0, 127, 31);           // both fields at their top
      offer(REQ_PUT, 8'h41, 0, 0);
      offer(REQ_PUT, 8'h00, 0, 0);            // lowest byte prints like any other
      offer(REQ_PUT, CH_BACKSPACE, 0, 0);     // steps back, blanks cell 1
      offer(REQ_PUT, CH_RETURN, 0, 0);
      offer(REQ_PUT, CH_BACKSPACE, 0, 0);     // at home: nothing happens
      offer(REQ_MOVE, '0, COLUMNS - 1, 0);
      offer(REQ_PUT, 8'hFF, 0, 0);            // last column: wraps to next row
      offer(REQ_PUT, CH_BACKSPACE, 0, 0);     // column 0: back to previous row's end
      offer(REQ_READ, '0, COLUMNS - 1, 0);
      offer(REQ_MOVE, '0, COLUMNS, 3);        // ignored moves
      offer(REQ_MOVE, '0, 3, ROWS);
      offer(REQ_MOVE, '0, 127, 31);
      offer(REQ_MOVE, '0, COLUMNS - 3, ROWS - 1);
      offer(REQ_PUT, CH_TAB, 0, 0);           // tab wraps mid-way and scrolls
      offer(REQ_PUT, CH_NEWLINE, 0, 0);       // newline on bottom row scrolls
      offer(REQ_READ, '0, 0, ROWS - 2);
      offer(REQ_MOVE, '0, COLUMNS - 1, ROWS - 1);
      offer(REQ_PUT, 8'h5A, 0, 0);            // printable at the very end: wrap and scroll
      offer(REQ_READ, '0, COLUMNS - 1, ROWS - 2);
      offer(REQ_CLEAR, '0, 0, 0);
      offer(REQ_PUT, CH_NEWLINE, 0, 0, 1'b1);
      drain();

      // Random phases, each under its own color; both extremes come first.
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       set_color(8'h00);
            1:       set_color(8'hFF);
            default: set_color(COLOR_W'($urandom_range(0, 255)));
         endcase
         for (int n = 0; n < WORDS_PER_PHASE; n++)
            send_word(pick_word(), n == WORDS_PER_PHASE - 1);
         drain();
      end

      $display("Covered %0d words: %0d puts (%0d tabs, %0d backspaces), %0d moves, %0d clears, %0d reads",
               books.kinds[REQ_PUT] + books.kinds[REQ_MOVE] + books.kinds[REQ_CLEAR] +
               books.kinds[REQ_READ], books.kinds[REQ_PUT], books.tabs, books.rubs,
               books.kinds[REQ_MOVE], books.kinds[REQ_CLEAR], books.kinds[REQ_READ]);
      $display("%0d scrolls, %0d color settings, %0d reports compared, %0d mismatches",
               books.scrolls, color_writes, books.checked, books.errors);
      if (books.errors == 0 && books.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin : watchdog
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

endmodule

### text_terminal_cell_engine.f
design/ttce_pkg.sv
design/ttce_cell_ram.sv
design/ttce_ctrl.sv
design/text_terminal_cell_engine.sv
bench/text_terminal_cell_engine_tb.sv
